// ===== design/dcfe_pkg.sv =====
// Shared types, codes and constants for the DER context field extractor.
`default_nettype none

package dcfe_pkg;

    // Longest long-form length accepted, in bytes, and the counter width that holds it
    localparam int MAX_LENGTH_BYTES = 4;
    localparam int LEN_CNT_W        = 3;

    // Byte roles
    localparam logic [2:0] ROLE_TAG     = 3'd0;
    localparam logic [2:0] ROLE_LENGTH  = 3'd1;
    localparam logic [2:0] ROLE_VALUE   = 3'd2;
    localparam logic [2:0] ROLE_INNER   = 3'd3;
    localparam logic [2:0] ROLE_IGNORED = 3'd4;

    // Error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_LEN_FORM   = 3'd1;
    localparam logic [2:0] ERR_TRUNCATED  = 3'd2;
    localparam logic [2:0] ERR_NOT_FOUND  = 3'd3;
    localparam logic [2:0] ERR_INNER_TAG  = 3'd4;
    localparam logic [2:0] ERR_INT_SIZE   = 3'd5;

    // Configuration register indexes
    localparam logic CFG_CONTEXT_NUMBER   = 1'b0;
    localparam logic CFG_WANTED_INNER_TAG = 1'b1;

    // Tag constants
    localparam logic [7:0] TAG_CTX_CONSTRUCTED = 8'hA0;
    localparam logic [7:0] TAG_CTX_PRIMITIVE   = 8'h80;
    localparam logic [7:0] TAG_INTEGER         = 8'h02;
    localparam logic [7:0] TAG_OCTET_STRING    = 8'h04;
    localparam logic [7:0] TAG_UTF8_STRING     = 8'h1B;
    localparam logic [7:0] TAG_BMP_STRING      = 8'h1E;

    // Payload byte count saturates here; an integer takes at most INT_MAX_BYTES
    localparam logic [2:0] PAYLOAD_SAT   = 3'd5;
    localparam logic [2:0] INT_MAX_BYTES = 3'd4;

    typedef enum logic [2:0] {
        PH_TAG,
        PH_LEN1,
        PH_LENX,
        PH_SKIP,
        PH_MATCH
    } parse_phase_t;

    typedef enum logic [2:0] {
        IN_TAG,
        IN_LEN1,
        IN_LENX,
        IN_VAL,
        IN_TRAIL,
        IN_BAD
    } inner_phase_t;

    typedef struct packed {
        parse_phase_t           parse_phase;
        logic [7:0]             current_tag;
        logic [LEN_CNT_W-1:0]   length_bytes_left;
        logic [31:0]            length_acc;
        logic [31:0]            value_bytes_left;
        inner_phase_t           inner_phase;
        logic [7:0]             inner_tag_seen;
        logic [31:0]            inner_bytes_left;
        logic [31:0]            integer_acc;
        logic                   search_done;
        logic [2:0]             payload_count;
    } parse_state_t;

    localparam parse_state_t RESET_STATE = '{
        parse_phase:       PH_TAG,
        current_tag:       8'h00,
        length_bytes_left: '0,
        length_acc:        32'h0,
        value_bytes_left:  32'h0,
        inner_phase:       IN_TAG,
        inner_tag_seen:    8'h00,
        inner_bytes_left:  32'h0,
        integer_acc:       32'h0,
        search_done:       1'b0,
        payload_count:     3'd0
    };

    typedef struct packed {
        logic [2:0]         byte_role;
        logic [7:0]         payload_byte;
        logic               payload_flag;
        logic [7:0]         element_tag;
        logic [31:0]        element_length;
        logic               result_valid;
        logic               found;
        logic signed [31:0] integer_value;
        logic               integer_ok;
        logic [2:0]         error_code;
    } result_t;

endpackage

`default_nettype wire

// ===== design/dcfe_parser.sv =====
// Per-byte TLV parse step: next parser state and the result word for one input byte.
`default_nettype none

module dcfe_parser
    import dcfe_pkg::*;
(
    input  wire parse_state_t st,
    input  wire logic [4:0]   context_number,
    input  wire logic [7:0]   wanted_inner_tag,
    input  wire logic [7:0]   data_byte,
    input  wire logic         last_byte,
    output parse_state_t      nx,
    output result_t           res
);

    logic [6:0] n_len;
    logic       matched;
    logic       prim_ok;
    logic       hdr;
    logic       fin;
    logic       take;
    logic       concl;
    logic       fin_ok;
    logic [2:0] cerr;

    assign matched = (st.current_tag == (TAG_CTX_CONSTRUCTED | {3'b000, context_number})) ||
                     (st.current_tag == (TAG_CTX_PRIMITIVE | {3'b000, context_number}));
    assign prim_ok = (wanted_inner_tag == TAG_INTEGER) ||
                     (wanted_inner_tag == TAG_OCTET_STRING) ||
                     (wanted_inner_tag == TAG_UTF8_STRING) ||
                     (wanted_inner_tag == TAG_BMP_STRING);
    assign n_len   = data_byte[6:0];

    always_comb
    begin
        nx     = st;
        res    = '0;
        hdr    = 1'b0;
        fin    = 1'b0;
        take   = 1'b0;
        concl  = 1'b0;
        fin_ok = 1'b0;
        cerr   = ERR_NONE;

        res.payload_byte = data_byte;

        if (st.search_done)
        begin
            res.byte_role = ROLE_IGNORED;
        end
        else
        begin
            case (st.parse_phase)
                PH_TAG:
                begin
                    res.byte_role = ROLE_TAG;
                    nx.current_tag = data_byte;
                    nx.length_acc  = 32'h0;
                    if (last_byte)
                    begin
                        concl = 1'b1;
                        cerr  = ERR_TRUNCATED;
                    end
                    else
                    begin
                        nx.parse_phase = PH_LEN1;
                    end
                end
                PH_LEN1:
                begin
                    res.byte_role = ROLE_LENGTH;
                    if (data_byte[7])
                    begin
                        if (n_len == 7'd0 || n_len > 7'(MAX_LENGTH_BYTES))
                        begin
                            concl = 1'b1;
                            cerr  = ERR_LEN_FORM;
                        end
                        else
                        begin
                            nx.length_bytes_left = n_len[LEN_CNT_W-1:0];
                            nx.length_acc        = 32'h0;
                            nx.parse_phase       = PH_LENX;
                            if (last_byte)
                            begin
                                concl = 1'b1;
                                cerr  = ERR_TRUNCATED;
                            end
                        end
                    end
                    else
                    begin
                        nx.length_acc = {24'h0, data_byte};
                        hdr = 1'b1;
                    end
                end
                PH_LENX:
                begin
                    res.byte_role = ROLE_LENGTH;
                    nx.length_acc = {st.length_acc[23:0], data_byte};
                    nx.length_bytes_left = st.length_bytes_left - LEN_CNT_W'(1);
                    if (nx.length_bytes_left == '0)
                    begin
                        hdr = 1'b1;
                    end
                    else if (last_byte)
                    begin
                        concl = 1'b1;
                        cerr  = ERR_TRUNCATED;
                    end
                end
                PH_SKIP:
                begin
                    res.byte_role = ROLE_VALUE;
                    nx.value_bytes_left = st.value_bytes_left - 32'd1;
                    if (nx.value_bytes_left == 32'h0)
                    begin
                        if (last_byte)
                        begin
                            concl = 1'b1;
                            cerr  = ERR_NOT_FOUND;
                        end
                        else
                        begin
                            nx.parse_phase = PH_TAG;
                        end
                    end
                    else if (last_byte)
                    begin
                        concl = 1'b1;
                        cerr  = ERR_TRUNCATED;
                    end
                end
                default:
                begin
                    res.byte_role = ROLE_VALUE;
                    if (st.current_tag[5])
                    begin
                        // unwrap the single inner TLV of a constructed match
                        case (st.inner_phase)
                            IN_TAG:
                            begin
                                res.byte_role     = ROLE_INNER;
                                nx.inner_tag_seen = data_byte;
                                nx.inner_phase    = IN_LEN1;
                            end
                            IN_LEN1:
                            begin
                                res.byte_role = ROLE_INNER;
                                if (data_byte[7])
                                begin
                                    if (n_len == 7'd0 || n_len > 7'(MAX_LENGTH_BYTES))
                                    begin
                                        nx.inner_phase = IN_BAD;
                                    end
                                    else
                                    begin
                                        nx.length_bytes_left = n_len[LEN_CNT_W-1:0];
                                        nx.inner_bytes_left  = 32'h0;
                                        nx.inner_phase       = IN_LENX;
                                    end
                                end
                                else
                                begin
                                    nx.inner_bytes_left = {24'h0, data_byte};
                                    nx.inner_phase = (data_byte != 8'h00) ? IN_VAL : IN_TRAIL;
                                end
                            end
                            IN_LENX:
                            begin
                                res.byte_role = ROLE_INNER;
                                nx.inner_bytes_left = {st.inner_bytes_left[23:0], data_byte};
                                nx.length_bytes_left = st.length_bytes_left - LEN_CNT_W'(1);
                                if (nx.length_bytes_left == '0)
                                begin
                                    nx.inner_phase = (nx.inner_bytes_left != 32'h0) ?
                                                     IN_VAL : IN_TRAIL;
                                end
                            end
                            IN_VAL:
                            begin
                                take = 1'b1;
                                nx.inner_bytes_left = st.inner_bytes_left - 32'd1;
                                if (nx.inner_bytes_left == 32'h0)
                                begin
                                    nx.inner_phase = IN_TRAIL;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    else if (prim_ok)
                    begin
                        take = 1'b1;
                    end
                    nx.value_bytes_left = st.value_bytes_left - 32'd1;
                    if (nx.value_bytes_left == 32'h0)
                    begin
                        fin = 1'b1;
                    end
                    else if (last_byte)
                    begin
                        concl = 1'b1;
                        cerr  = ERR_TRUNCATED;
                    end
                end
            endcase
        end

        // Collect a payload byte; first byte sign-extends
        if (take)
        begin
            res.payload_flag = 1'b1;
            if (st.payload_count == 3'd0)
            begin
                nx.integer_acc = {{24{data_byte[7]}}, data_byte};
            end
            else
            begin
                nx.integer_acc = {st.integer_acc[23:0], data_byte};
            end
            if (st.payload_count < PAYLOAD_SAT)
            begin
                nx.payload_count = st.payload_count + 3'd1;
            end
        end

        // Header complete: arm value tracking
        if (hdr)
        begin
            nx.value_bytes_left = nx.length_acc;
            nx.inner_phase      = IN_TAG;
            nx.inner_tag_seen   = 8'h00;
            nx.inner_bytes_left = 32'h0;
            nx.integer_acc      = 32'h0;
            nx.payload_count    = 3'd0;
            if (nx.length_acc == 32'h0)
            begin
                if (matched)
                begin
                    fin = 1'b1;
                end
                else if (last_byte)
                begin
                    concl = 1'b1;
                    cerr  = ERR_NOT_FOUND;
                end
                else
                begin
                    nx.parse_phase = PH_TAG;
                end
            end
            else if (last_byte)
            begin
                concl = 1'b1;
                cerr  = ERR_TRUNCATED;
            end
            else
            begin
                nx.parse_phase = matched ? PH_MATCH : PH_SKIP;
            end
        end

        // Matched element ends: judge it
        if (fin)
        begin
            concl = 1'b1;
            if (nx.current_tag[5])
            begin
                if (nx.inner_phase == IN_BAD)
                begin
                    cerr = ERR_LEN_FORM;
                end
                else if (nx.inner_phase != IN_TRAIL)
                begin
                    cerr = ERR_TRUNCATED;
                end
                else if (nx.inner_tag_seen != wanted_inner_tag)
                begin
                    cerr = ERR_INNER_TAG;
                end
                else
                begin
                    fin_ok = 1'b1;
                end
            end
            else if (!prim_ok)
            begin
                cerr = ERR_INNER_TAG;
            end
            else
            begin
                fin_ok = 1'b1;
            end

            if (fin_ok)
            begin
                cerr      = ERR_NONE;
                res.found = 1'b1;
                if (wanted_inner_tag == TAG_INTEGER)
                begin
                    if (nx.payload_count >= 3'd1 && nx.payload_count <= INT_MAX_BYTES)
                    begin
                        res.integer_ok    = 1'b1;
                        res.integer_value = nx.integer_acc;
                    end
                    else
                    begin
                        cerr = ERR_INT_SIZE;
                    end
                end
            end
        end

        if (concl)
        begin
            res.result_valid = 1'b1;
            res.error_code   = cerr;
            nx.search_done   = 1'b1;
        end

        res.element_tag    = nx.current_tag;
        res.element_length = nx.length_acc;

        // End of sequence: start over on the next byte
        if (last_byte)
        begin
            nx = RESET_STATE;
        end
    end

endmodule

`default_nettype wire

// ===== design/der_context_field_extractor_top.sv =====
// Result words are registered: into the output register, or the skid entry if stalled.
// Throughput: one byte per cycle unless in_stall; one parse pass between state registers.
// The output side has a result register plus one skid entry, so input stall is registered
// and asserts only when both hold words.
// Reset (rst_n low, asynchronous): parser returns to expecting a tag, outputs empty,
// context_number to 0 and wanted_inner_tag to 0x02.
`default_nettype none

module der_context_field_extractor_top
    import dcfe_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write_en,
    input  wire logic               cfg_index,
    input  wire logic [7:0]         cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last_byte,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              byte_role,
    output logic [7:0]              payload_byte,
    output logic                    payload_flag,
    output logic [7:0]              element_tag,
    output logic [31:0]             element_length,
    output logic                    result_valid,
    output logic                    found,
    output logic signed [31:0]      integer_value,
    output logic                    integer_ok,
    output logic [2:0]              error_code
);

    logic [4:0]   context_number_reg;
    logic [7:0]   wanted_inner_tag_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      step_res;
    result_t      out_reg;
    result_t      skid_reg;
    logic         out_valid_reg;
    logic         skid_valid_reg;
    logic         accept;
    logic         out_free;

    assign accept   = in_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;

    dcfe_parser u_parser (
        .st               (state_reg),
        .context_number   (context_number_reg),
        .wanted_inner_tag (wanted_inner_tag_reg),
        .data_byte        (data_byte),
        .last_byte        (last_byte),
        .nx               (state_next),
        .res              (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            context_number_reg   <= 5'd0;
            wanted_inner_tag_reg <= TAG_INTEGER;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_CONTEXT_NUMBER:   context_number_reg   <= cfg_data[4:0];
                CFG_WANTED_INNER_TAG: wanted_inner_tag_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RESET_STATE;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Output register and skid entry valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (accept)
            begin
                out_reg <= step_res;
            end
        end
        else if (accept)
        begin
            skid_reg <= step_res;
        end
    end

    assign in_stall       = skid_valid_reg;
    assign out_valid      = out_valid_reg;
    assign byte_role      = out_reg.byte_role;
    assign payload_byte   = out_reg.payload_byte;
    assign payload_flag   = out_reg.payload_flag;
    assign element_tag    = out_reg.element_tag;
    assign element_length = out_reg.element_length;
    assign result_valid   = out_reg.result_valid;
    assign found          = out_reg.found;
    assign integer_value  = out_reg.integer_value;
    assign integer_ok     = out_reg.integer_ok;
    assign error_code     = out_reg.error_code;

endmodule

`default_nettype wire

// ===== design/dcfe_checker.sv =====
// Port-level assertions for the DER context field extractor, bound to the top level.
`default_nettype none

module dcfe_checker
    import dcfe_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               cfg_write_en,
    input wire logic               cfg_index,
    input wire logic [7:0]         cfg_data,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic [7:0]         data_byte,
    input wire logic               last_byte,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [2:0]         byte_role,
    input wire logic [7:0]         payload_byte,
    input wire logic               payload_flag,
    input wire logic [7:0]         element_tag,
    input wire logic [31:0]        element_length,
    input wire logic               result_valid,
    input wire logic               found,
    input wire logic signed [31:0] integer_value,
    input wire logic               integer_ok,
    input wire logic [2:0]         error_code
);

    // Input stalls only while a word is already held at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // Verdict fields stay clear except on the concluding word
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !result_valid) |->
            (!found && !integer_ok && error_code == ERR_NONE && integer_value == 32'sd0))
        else $error("verdict fields set without result_valid");

    // A decoded integer only comes with a clean find
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && integer_ok) |-> (found && result_valid && error_code == ERR_NONE))
        else $error("integer_ok without a clean find");

    // Found carries no error other than a bad integer size
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (error_code == ERR_NONE || error_code == ERR_INT_SIZE))
        else $error("found with unexpected error code");

    // A held output word does not change
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(byte_role) && $stable(payload_byte) &&
             $stable(result_valid) && $stable(error_code)))
        else $error("stalled output word changed");

endmodule

bind der_context_field_extractor_top dcfe_checker u_dcfe_checker (.*);

`default_nettype wire
